// ===== src/uhrs_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 Hangul run splitter.
`default_nettype none

package uhrs_pkg;

    // Configuration register indexes.
    localparam logic [0:0] CFG_PRIMARY_HANGUL   = 1'b0;
    localparam logic [0:0] CFG_FALLBACK_PRESENT = 1'b1;

    localparam logic [20:0] HANGUL_FIRST = 21'h00AC00;
    localparam logic [20:0] HANGUL_LAST  = 21'h00D7A3;

    // One decoded character.
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
        logic        hangul;
    } t_char;

    // One result as it waits in the output buffer.
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
        logic        hangul;
        logic        run_start;
        logic        fallback;
        logic        done;
    } t_result;

    // Sequence length announced by a lead byte; stray bytes stand alone.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] l;
        if (b[7] == 1'b0) begin
            l = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            l = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            l = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            l = 3'd4;
        end else begin
            l = 3'd1;
        end
        return l;
    endfunction

    // Decodes the character that starts at b0, with avail bytes left in the text.
    // A lead whose sequence does not fit is taken as a byte of its own.
    function automatic t_char char_decode(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] avail);
        t_char      c;
        logic [2:0] l;
        l = lead_len(b0);
        if (l > avail) begin
            l = 3'd1;
        end
        case (l)
            3'd2: c.cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3: c.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4: c.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: begin
                c.cp = {13'd0, b0};
                l    = 3'd1;
            end
        endcase
        c.len    = l;
        c.hangul = (c.cp >= HANGUL_FIRST) && (c.cp <= HANGUL_LAST);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/utf8_decode_hangul_run_split_top.sv =====
// Top level of the UTF-8 decoder with Hangul run segmentation.
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      i_text_byte, i_end_of_text
//  out       output     o_out_valid / i_out_ready    o_code_point .. o_text_done
//  cfg       input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// A byte is registered on transfer and then decoded into up to four results, which
// enter a four-entry output buffer once it is free. While the receiver is ready,
// results drain one per cycle and, as most bytes give zero or one result, one byte
// per cycle is sustained. A byte that ends the text inside a sequence gives up to
// four results; the input then stalls until all but the last of them have been
// transferred out. Reset clears the held and buffer counts and the run state.
`default_nettype none

module utf8_decode_hangul_run_split_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [0:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [20:0]      o_code_point,
    output logic [2:0]       o_byte_length,
    output logic             o_is_hangul,
    output logic             o_run_start,
    output logic             o_use_fallback_font,
    output logic             o_text_done
);

    logic                         r_primary_hangul;
    logic                         r_fallback_present;
    logic                         r_in_valid;
    logic [7:0]                   r_byte;
    logic                         r_eot;
    logic [7:0]                   r_held [0:2];
    logic [1:0]                   r_held_cnt;
    logic [2:0]                   r_seq_len;
    logic                         r_prev_hangul;
    logic                         r_first;
    uhrs_pkg::t_result            r_res [0:3];
    logic [2:0]                   r_cnt;

    logic [3:0][7:0]              w_buf;
    logic [2:0]                   w_n;
    logic [2:0]                   w_lead_len;
    logic                         w_emit;
    uhrs_pkg::t_char [3:0]        w_dec;
    logic [2:0]                   w_dec_num;
    logic [2:0]                   w_num;
    logic [1:0]                   w_last;
    uhrs_pkg::t_result [3:0]      w_res;
    logic                         w_pop;
    logic                         w_free;
    logic                         w_consume;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_hangul   <= 1'b0;
            r_fallback_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uhrs_pkg::CFG_PRIMARY_HANGUL:   r_primary_hangul   <= i_cfg_data[0];
                uhrs_pkg::CFG_FALLBACK_PRESENT: r_fallback_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Held bytes followed by the new byte.
    for (genvar i = 0; i < 3; i++) begin : g_buf
        assign w_buf[i] = (2'(i) < r_held_cnt) ? r_held[i] : r_byte;
    end
    assign w_buf[3] = r_byte;
    assign w_n      = {1'b0, r_held_cnt} + 3'd1;

    uhrs_decode u_decode (
        .i_bytes (w_buf),
        .i_count (w_n),
        .o_chars (w_dec),
        .o_num   (w_dec_num)
    );

    assign w_lead_len = uhrs_pkg::lead_len(r_byte);

    // Without end of text, a byte completes at most one character.
    assign w_emit = r_eot || ((r_held_cnt == 2'd0) ? (w_lead_len == 3'd1)
                                                    : (w_n >= r_seq_len));
    assign w_num  = r_eot ? w_dec_num : (w_emit ? 3'd1 : 3'd0);
    assign w_last = 2'(w_num - 3'd1);

    for (genvar j = 0; j < 4; j++) begin : g_res
        assign w_res[j].cp       = w_dec[j].cp;
        assign w_res[j].len      = w_dec[j].len;
        assign w_res[j].hangul   = w_dec[j].hangul;
        assign w_res[j].fallback = w_dec[j].hangul && !r_primary_hangul && r_fallback_present;
        assign w_res[j].done     = r_eot && (w_last == 2'(j));
        if (j == 0) begin : g_head
            assign w_res[j].run_start = r_first || (w_dec[j].hangul != r_prev_hangul);
        end else begin : g_tail
            assign w_res[j].run_start = w_dec[j].hangul != w_dec[j - 1].hangul;
        end
    end

    // The buffer takes a new set only when it is empty or its last entry leaves now.
    assign w_pop      = (r_cnt != 3'd0) && i_out_ready;
    assign w_free     = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && w_pop);
    assign w_consume  = r_in_valid && w_free;
    assign o_in_ready = !r_in_valid || w_consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
    end

    // Sequence and run state, advanced as each byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt    <= 2'd0;
            r_seq_len     <= 3'd0;
            r_prev_hangul <= 1'b0;
            r_first       <= 1'b1;
        end else if (w_consume) begin
            if (w_num != 3'd0) begin
                r_prev_hangul <= w_dec[w_last].hangul;
                r_first       <= 1'b0;
            end
            if (r_eot) begin
                r_held_cnt <= 2'd0;
                r_seq_len  <= 3'd0;
                r_first    <= 1'b1;
            end else if (w_emit) begin
                r_held_cnt <= 2'd0;
                r_seq_len  <= 3'd0;
            end else begin
                r_held_cnt <= r_held_cnt + 2'd1;
                if (r_held_cnt == 2'd0) begin
                    r_seq_len <= w_lead_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && !r_eot && !w_emit) begin
            r_held[r_held_cnt] <= r_byte;
        end
    end

    // Output buffer: entry 0 is presented, the rest shift down on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_consume) begin
            r_cnt <= w_num;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_res[0] <= w_res[0];
            r_res[1] <= w_res[1];
            r_res[2] <= w_res[2];
            r_res[3] <= w_res[3];
        end else if (w_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
            r_res[2] <= r_res[3];
        end
    end

    assign o_out_valid         = r_cnt != 3'd0;
    assign o_code_point        = r_res[0].cp;
    assign o_byte_length       = r_res[0].len;
    assign o_is_hangul         = r_res[0].hangul;
    assign o_run_start         = r_res[0].run_start;
    assign o_use_fallback_font = r_res[0].fallback;
    assign o_text_done         = r_res[0].done;

    // A held sequence always announces more bytes than are held.
    a_held_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != 2'd0) |-> (r_seq_len > {1'b0, r_held_cnt}))
        else $error("held byte count reached the announced sequence length");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("output buffer count out of range");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_done) |-> (r_cnt == 3'd1))
        else $error("end of text result is not the last one buffered");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume |-> (r_cnt == 3'd0 || (r_cnt == 3'd1 && i_out_ready)))
        else $error("decoded results would overwrite pending results");

endmodule

`default_nettype wire

// ===== src/uhrs_decode.sv =====
// Splits a buffer of up to four text bytes into its sequence of characters.
`default_nettype none

module uhrs_decode (
    input  wire logic [3:0][7:0]         i_bytes,
    input  wire logic [2:0]              i_count,
    output uhrs_pkg::t_char [3:0]        o_chars,
    output logic [2:0]                   o_num
);

    logic [6:0][7:0]        w_pad;
    uhrs_pkg::t_char [3:0]  w_at;
    logic [3:0][3:0]        w_pos;
    logic [3:0]             w_valid;

    assign w_pad = {24'd0, i_bytes};

    // A candidate character at every byte position.
    for (genvar s = 0; s < 4; s++) begin : g_pos
        assign w_at[s] = uhrs_pkg::char_decode(w_pad[s], w_pad[s + 1], w_pad[s + 2],
                                               w_pad[s + 3], i_count - 3'(s));
    end

    // Walk the buffer: each character starts where the previous one ended.
    // Positions past the end keep growing, so they stay wide enough not to wrap.
    assign w_pos[0] = 4'd0;
    for (genvar j = 0; j < 4; j++) begin : g_walk
        assign w_valid[j]   = w_pos[j] < {1'b0, i_count};
        assign o_chars[j]   = w_at[w_pos[j][1:0]];
        if (j < 3) begin : g_next
            assign w_pos[j + 1] = w_pos[j] + {1'b0, w_at[w_pos[j][1:0]].len};
        end
    end

    assign o_num = 3'(w_valid[0]) + 3'(w_valid[1]) + 3'(w_valid[2]) + 3'(w_valid[3]);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 decoder with Hangul run segmentation.
module tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Directed text: bit 8 marks the final byte of a text.
    localparam logic [8:0] DIRECTED_ITEMS [25] = '{
        9'h000, 9'h07F,                 // ASCII extremes
        9'h0C3, 9'h0A9,                 // two-byte character
        9'h0EA, 9'h0B0, 9'h080,         // first Hangul syllable
        9'h0ED, 9'h09E, 9'h0A3,         // last Hangul syllable, same run
        9'h0ED, 9'h09E, 9'h0A4,         // just past the Hangul block
        9'h080, 9'h0FF,                 // stray continuation and invalid lead
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF, // largest four-byte code point, text ends
        9'h0F0, 9'h0E0, 9'h1E0,         // text ends with two unfinished leads held
        9'h0E2, 9'h141,                 // text ends one byte into a sequence
        9'h1C3                          // text is a lone lead byte
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [0:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [20:0] o_code_point;
    logic [2:0]  o_byte_length;
    logic        o_is_hangul;
    logic        o_run_start;
    logic        o_use_fallback_font;
    logic        o_text_done;

    utf8_decode_hangul_run_split_top u_dut (.*);

    // Predictor state.
    logic [7:0]          held_q [3];
    int unsigned         held_n;
    int unsigned         seq_need;
    logic                last_hangul;
    logic                text_fresh;
    logic                cfg_primary_hangul;
    logic                cfg_fallback_present;
    uhrs_pkg::t_result   burst [4];
    int unsigned         burst_n;
    uhrs_pkg::t_result   expected_chars [$];

    logic [7:0]  text_bytes [$];
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned out_hold_left;
    int unsigned fail_count;
    int unsigned cycle_count;

    function automatic int unsigned seq_bytes(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    function automatic void emit_char(input logic [20:0] cp, input logic [2:0] len);
        uhrs_pkg::t_result r;
        r.cp        = cp;
        r.len       = len;
        r.hangul    = (cp >= uhrs_pkg::HANGUL_FIRST) && (cp <= uhrs_pkg::HANGUL_LAST);
        r.run_start = text_fresh || (r.hangul != last_hangul);
        r.fallback  = r.hangul && !cfg_primary_hangul && cfg_fallback_present;
        r.done      = 1'b0;
        last_hangul = r.hangul;
        text_fresh  = 1'b0;
        burst[burst_n] = r;
        burst_n++;
    endfunction

    // Decodes n bytes as if the text ended after them; leads that do not fit stand alone.
    function automatic void decode_span(input logic [7:0] span [4], input int unsigned n);
        int unsigned p;
        int unsigned len;
        logic [7:0]  b;
        logic [20:0] cp;
        p = 0;
        while (p < n && burst_n < 4) begin
            b   = span[p];
            len = seq_bytes(b);
            if (len > 1 && p + len > n) len = 1;
            case (len)
                2: cp = {10'd0, b[4:0], span[p+1][5:0]};
                3: cp = {5'd0, b[3:0], span[p+1][5:0], span[p+2][5:0]};
                4: cp = {b[2:0], span[p+1][5:0], span[p+2][5:0], span[p+3][5:0]};
                default: cp = {13'd0, b};
            endcase
            emit_char(cp, 3'(len));
            p += len;
        end
    endfunction

    function automatic void predict_from_byte(input logic [7:0] b, input logic eot);
        logic [7:0]  span [4];
        int unsigned n;
        n = 0;
        burst_n = 0;
        for (int i = 0; i < 4; i++) span[i] = 8'h00;
        for (int i = 0; i < held_n; i++) begin
            span[n] = held_q[i];
            n++;
        end
        span[n] = b;
        n++;
        if (eot) begin
            decode_span(span, n);
            if (burst_n > 0) burst[burst_n-1].done = 1'b1;
            held_n     = 0;
            seq_need   = 0;
            text_fresh = 1'b1;
        end else if (held_n == 0) begin
            if (seq_bytes(b) == 1) begin
                decode_span(span, 1);
            end else begin
                held_q[0] = b;
                held_n    = 1;
                seq_need  = seq_bytes(b);
            end
        end else if (n >= seq_need) begin
            decode_span(span, n);
            held_n   = 0;
            seq_need = 0;
        end else begin
            held_q[held_n] = b;
            held_n++;
        end
        for (int i = 0; i < burst_n; i++) expected_chars = {expected_chars, burst[i]};
    endfunction

    function automatic void check_field(input string name, input logic [20:0] want,
                                        input logic [20:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // The block ignores the top two bits of a trailing byte, so vary them now and then.
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        if ($urandom_range(3) == 0) return {2'($urandom_range(3)), bits};
        return {2'b10, bits};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf8_decode_hangul_run_split_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_left > 0) begin
                out_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : char_check
        uhrs_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character transfer: code_point %0h", o_code_point);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                check_field("code_point", want.cp, o_code_point);
                check_field("byte_length", want.len, o_byte_length);
                check_field("is_hangul", want.hangul, o_is_hangul);
                check_field("run_start", want.run_start, o_run_start);
                check_field("use_fallback_font", want.fallback, o_use_fallback_font);
                check_field("text_done", want.done, o_text_done);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        predict_from_byte(b, eot);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    // Stops offering bytes and waits until every expected character has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        if (idx == uhrs_pkg::CFG_PRIMARY_HANGUL) cfg_primary_hangul = d;
        else cfg_fallback_present = d;
    endtask

    task automatic set_fonts(input logic primary, input logic fallback);
        wait_idle();
        write_cfg(uhrs_pkg::CFG_PRIMARY_HANGUL, primary);
        write_cfg(uhrs_pkg::CFG_FALLBACK_PRESENT, fallback);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Builds one text of mostly well-formed characters, sometimes cut off at the end.
    task automatic compose_text();
        int unsigned nchars;
        int unsigned kind;
        int unsigned need;
        logic [20:0] cp;
        logic [31:0] r;
        text_bytes.delete();
        nchars = $urandom_range(6, 1);
        repeat (nchars) begin
            kind = $urandom_range(99);
            cp   = 21'($urandom);
            if (kind < 25) begin
                text_bytes = {text_bytes, {1'b0, cp[6:0]}};
            end else if (kind < 35) begin
                text_bytes = {text_bytes, {3'b110, cp[10:6]}};
                text_bytes = {text_bytes, cont_byte(cp[5:0])};
            end else if (kind < 75) begin
                if (kind < 65) begin
                    cp = 21'($urandom_range(uhrs_pkg::HANGUL_LAST, uhrs_pkg::HANGUL_FIRST));
                end
                text_bytes = {text_bytes, {4'b1110, cp[15:12]}};
                text_bytes = {text_bytes, cont_byte(cp[11:6])};
                text_bytes = {text_bytes, cont_byte(cp[5:0])};
            end else if (kind < 88) begin
                text_bytes = {text_bytes, {5'b11110, cp[20:18]}};
                text_bytes = {text_bytes, cont_byte(cp[17:12])};
                text_bytes = {text_bytes, cont_byte(cp[11:6])};
                text_bytes = {text_bytes, cont_byte(cp[5:0])};
            end else begin
                text_bytes = {text_bytes, 8'($urandom_range(255))};
            end
        end
        if ($urandom_range(99) < 20) begin
            need = $urandom_range(4, 2);
            r    = $urandom;
            case (need)
                2:       text_bytes = {text_bytes, {3'b110, r[4:0]}};
                3:       text_bytes = {text_bytes, {4'b1110, r[3:0]}};
                default: text_bytes = {text_bytes, {5'b11110, r[2:0]}};
            endcase
            repeat ($urandom_range(need - 2)) text_bytes = {text_bytes, cont_byte(r[13:8])};
        end
    endtask

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        foreach (DIRECTED_ITEMS[i]) send_byte(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
    endtask

    task automatic test_random_texts(input int unsigned min_bytes, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned sent;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < min_bytes) begin
            compose_text();
            send_text();
            sent += text_bytes.size();
        end
    endtask

    // The receiver holds off long enough for the output buffer to fill and the input to stall.
    task automatic test_output_hold();
        int unsigned sent;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        out_hold_left      = 80;
        sent = 0;
        while (sent < 12) begin
            compose_text();
            send_text();
            sent += text_bytes.size();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = uhrs_pkg::CFG_PRIMARY_HANGUL;
        i_cfg_data           = 1'b0;
        i_in_valid           = 1'b0;
        i_text_byte          = 8'h00;
        i_end_of_text        = 1'b0;
        held_n               = 0;
        seq_need             = 0;
        last_hangul          = 1'b0;
        text_fresh           = 1'b1;
        cfg_primary_hangul   = 1'b0;
        cfg_fallback_present = 1'b0;
        burst_n              = 0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        out_hold_left        = 0;
        fail_count           = 0;
        cycle_count          = 0;
        for (int i = 0; i < 3; i++) held_q[i] = 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_fonts(1'b0, 1'b1);
        test_directed();
        test_random_texts(12, 0, 0);
        set_fonts(1'b1, 1'b1);
        test_random_texts(12, 71, 0);
        set_fonts(1'b0, 1'b0);
        test_random_texts(12, 0, 71);
        set_fonts(1'b1, 1'b0);
        test_random_texts(12, 26, 26);
        set_fonts(1'b0, 1'b1);
        test_output_hold();
        wait_idle();

        if (fail_count == 0) begin
            $display("utf8_decode_hangul_run_split_top verification clean");
        end else begin
            $display("utf8_decode_hangul_run_split_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/uhrs_pkg.sv
src/uhrs_decode.sv
src/utf8_decode_hangul_run_split_top.sv
tb/tb.sv
